// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen on a rising clock edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ----- hw/rtl/tfa_pkg.sv -----
// Shared constants and types of the thruster force allocation block.
`default_nettype none

package tfa_pkg;

  localparam int NUM_PROP   = 4;
  localparam int NUM_AXES   = 6;
  localparam int POLY_TERMS = 4;

  localparam int COEF_DEPTH = 2 * POLY_TERMS;
  localparam int MAT_DEPTH  = NUM_AXES * NUM_PROP;

  localparam int COEF_IDX_W = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
  localparam int MAT_IDX_W  = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;
  localparam int PROP_W     = (NUM_PROP > 1) ? $clog2(NUM_PROP) : 1;
  localparam int AXIS_W     = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  localparam int CAP_W      = $clog2(NUM_AXES + 1);
  localparam int TERM_W     = (POLY_TERMS > 1) ? $clog2(POLY_TERMS) : 1;

  // Field widths and positions of the streams
  localparam int OP_W       = 2;
  localparam int IDX_W      = 5;
  localparam int VAL_W      = 32;
  localparam int VOLT_W     = 16;
  localparam int DZ_W       = 15;
  localparam int IDX_LSB    = 0;
  localparam int VAL_LSB    = IDX_LSB + IDX_W;
  localparam int VOLT_LSB   = VAL_LSB + VAL_W;
  localparam int IN_BITS    = VOLT_LSB + 4 * VOLT_W;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = NUM_AXES * VAL_W;

  localparam logic [DZ_W-1:0] DZ_RESET = DZ_W'(128);

  // Shared multiply-accumulate unit
  localparam int MUL_A_W      = 48;
  localparam int MUL_B_W      = 17;
  localparam int PROD_W       = MUL_A_W + MUL_B_W;
  localparam int HORNER_W     = 48;
  localparam int HSUM_W       = HORNER_W + 10;
  localparam int ACC_W        = 52;
  localparam int HORNER_SHIFT = 8;
  localparam int MAT_SHIFT    = 16;

  typedef enum logic [OP_W-1:0] {
    OP_COEF   = 2'd0,
    OP_MAT    = 2'd1,
    OP_THRUST = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    MAC_HORNER = 2'd0,
    MAC_ADD_HI = 2'd1,
    MAC_ADD_LO = 2'd2
  } mac_mode_t;

  typedef struct packed {
    logic      issue;
    mac_mode_t mode;
    logic      first;
    logic      last;
  } mac_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tfa_mac.sv -----
// Shared 48x17 multiplier with rounding, saturating Horner step and accumulator.
`default_nettype none
`include "assert_macros.svh"

module tfa_mac (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire tfa_pkg::mac_ctrl_t                    ctrl,
  input  wire logic signed [tfa_pkg::MUL_A_W-1:0]    op_a,
  input  wire logic signed [tfa_pkg::MUL_B_W-1:0]    op_b,
  input  wire logic signed [tfa_pkg::VAL_W-1:0]      addend,
  output logic signed [tfa_pkg::ACC_W-1:0]           acc,
  output logic                                       done
);

  localparam logic signed [tfa_pkg::PROD_W-1:0] HALF_H =
    tfa_pkg::PROD_W'(1) << (tfa_pkg::HORNER_SHIFT - 1);
  localparam logic signed [tfa_pkg::PROD_W-1:0] HALF_M =
    tfa_pkg::PROD_W'(1) << (tfa_pkg::MAT_SHIFT - 1);
  localparam logic signed [tfa_pkg::HSUM_W-1:0] H_MAX =
    {{(tfa_pkg::HSUM_W - tfa_pkg::HORNER_W + 1){1'b0}}, {(tfa_pkg::HORNER_W - 1){1'b1}}};
  localparam logic signed [tfa_pkg::HSUM_W-1:0] H_MIN =
    {{(tfa_pkg::HSUM_W - tfa_pkg::HORNER_W + 1){1'b1}}, {(tfa_pkg::HORNER_W - 1){1'b0}}};

  logic signed [tfa_pkg::PROD_W-1:0] prod_c;
  logic signed [tfa_pkg::PROD_W-1:0] prod_r;
  logic signed [tfa_pkg::PROD_W-1:0] rnd_h;
  logic signed [tfa_pkg::PROD_W-1:0] rnd_m;
  logic signed [tfa_pkg::HSUM_W-1:0] hsum;
  logic signed [tfa_pkg::HORNER_W-1:0] hsat;
  logic signed [tfa_pkg::ACC_W-1:0]  acc_r;
  logic signed [tfa_pkg::ACC_W-1:0]  acc_nxt;
  logic signed [tfa_pkg::ACC_W-1:0]  base;
  logic signed [tfa_pkg::VAL_W-1:0]  addend_r;
  tfa_pkg::mac_mode_t                mode_r;
  logic                              first_r;
  logic                              last_r;
  logic                              vld_r;
  logic                              done_r;
  logic                              last_issue;
  logic                              horner_upd;
  logic [tfa_pkg::ACC_W-tfa_pkg::HORNER_W:0] acc_top;

  assign prod_c = op_a * op_b;

  // Payload stage: product and its control
  always_ff @(posedge clk) begin
    prod_r   <= prod_c;
    addend_r <= addend;
    mode_r   <= ctrl.mode;
    first_r  <= ctrl.first;
    last_r   <= ctrl.last;
  end

  always_comb begin
    rnd_h = (prod_r + HALF_H) >>> tfa_pkg::HORNER_SHIFT;
    rnd_m = (prod_r + HALF_M) >>> tfa_pkg::MAT_SHIFT;
    hsum  = tfa_pkg::HSUM_W'(rnd_h) + tfa_pkg::HSUM_W'(addend_r);
    if (hsum > H_MAX) begin
      hsat = H_MAX[tfa_pkg::HORNER_W-1:0];
    end else if (hsum < H_MIN) begin
      hsat = H_MIN[tfa_pkg::HORNER_W-1:0];
    end else begin
      hsat = hsum[tfa_pkg::HORNER_W-1:0];
    end
    base = first_r ? '0 : acc_r;
    unique case (mode_r)
      tfa_pkg::MAC_HORNER: acc_nxt = tfa_pkg::ACC_W'(hsat);
      // upper half of the thrust: exact, already in Q16.16 with no shift needed
      tfa_pkg::MAC_ADD_HI: acc_nxt = base + tfa_pkg::ACC_W'(prod_r);
      tfa_pkg::MAC_ADD_LO: acc_nxt = base + tfa_pkg::ACC_W'(rnd_m);
      default:             acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      vld_r  <= ctrl.issue;
      done_r <= vld_r & last_r;
    end
    if (vld_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc  = acc_r;
  assign done = done_r;

  assign last_issue = ctrl.issue & ctrl.last;
  assign horner_upd = vld_r & (mode_r == tfa_pkg::MAC_HORNER);
  assign acc_top    = acc_r[tfa_pkg::ACC_W-1:tfa_pkg::HORNER_W-1];

  `ASSERT_PROP(a_done_latency, last_issue |=> ##1 done, "mac: done missing after last issue")
  `ASSERT_PROP(a_done_source, done |-> $past(last_issue, 2), "mac: done without a last issue")
  `ASSERT_PROP(a_horner_range, $past(horner_upd) |-> (&acc_top || ~|acc_top), "mac: Horner overflow")

endmodule

`default_nettype wire

// ----- hw/rtl/thruster_force_allocation.sv -----
// Thruster force allocation top level: tables, sequencer and output register.
// Table writes are taken only while idle. A thrust request runs, on the single
// 48x17 multiply-accumulate unit, the Horner chain per propeller outside the dead
// zone (force 0 inside) and then the matrix in two thrust halves per element; the
// output loads once the previous result is taken, and only then is a new request taken.
// Synchronous active-low reset: idle, no result, dead zone 0.5 V; tables undefined.
`default_nettype none
`include "assert_macros.svh"

module thruster_force_allocation (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // table_index, table_value, volt_0, volt_1, volt_2, volt_3, zero pad
  input  wire logic [tfa_pkg::IN_DATA_W-1:0]      in_tdata,
  // op
  input  wire logic [tfa_pkg::OP_W-1:0]           in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // force_x, force_y, force_z, torque_roll, torque_pitch, torque_yaw
  output logic [tfa_pkg::OUT_DATA_W-1:0]          out_tdata,
  input  wire logic                               cfg_we,
  input  wire logic [tfa_pkg::DZ_W-1:0]           cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POLY,
    S_POLY_WAIT,
    S_MAT,
    S_MAT_WAIT,
    S_DONE
  } state_t;

  localparam logic [tfa_pkg::PROP_W-1:0] PROP_LAST = tfa_pkg::PROP_W'(tfa_pkg::NUM_PROP - 1);
  localparam logic [tfa_pkg::AXIS_W-1:0] AXIS_LAST = tfa_pkg::AXIS_W'(tfa_pkg::NUM_AXES - 1);
  localparam logic [tfa_pkg::CAP_W-1:0]  CAP_LAST  = tfa_pkg::CAP_W'(tfa_pkg::NUM_AXES - 1);
  localparam logic [tfa_pkg::TERM_W-1:0] TERM_LAST = tfa_pkg::TERM_W'(tfa_pkg::POLY_TERMS - 1);
  localparam logic signed [tfa_pkg::ACC_W-1:0] S32_MAX =
    {{(tfa_pkg::ACC_W - 31){1'b0}}, {31{1'b1}}};
  localparam logic signed [tfa_pkg::ACC_W-1:0] S32_MIN =
    {{(tfa_pkg::ACC_W - 31){1'b1}}, {31{1'b0}}};

  function automatic logic signed [tfa_pkg::VAL_W-1:0] sat32(
    input logic signed [tfa_pkg::ACC_W-1:0] x
  );
    logic signed [tfa_pkg::VAL_W-1:0] r;
    if (x > S32_MAX) begin
      r = S32_MAX[tfa_pkg::VAL_W-1:0];
    end else if (x < S32_MIN) begin
      r = S32_MIN[tfa_pkg::VAL_W-1:0];
    end else begin
      r = x[tfa_pkg::VAL_W-1:0];
    end
    return r;
  endfunction

  state_t                                state_r;
  logic [tfa_pkg::DZ_W-1:0]              dead_zone_r;
  logic signed [tfa_pkg::VAL_W-1:0]      coef_r [tfa_pkg::COEF_DEPTH];
  logic signed [tfa_pkg::VAL_W-1:0]      mat_r [tfa_pkg::MAT_DEPTH];
  logic signed [tfa_pkg::VOLT_W-1:0]     volt_r [tfa_pkg::NUM_PROP];
  logic signed [tfa_pkg::VAL_W-1:0]      force_r [tfa_pkg::NUM_PROP];
  logic signed [tfa_pkg::VAL_W-1:0]      axis_res_r [tfa_pkg::NUM_AXES];
  logic [tfa_pkg::OUT_DATA_W-1:0]        out_data_r;
  logic                                  out_tvalid_r;
  logic [tfa_pkg::PROP_W-1:0]            prop_r;
  logic [tfa_pkg::TERM_W-1:0]            term_r;
  logic [tfa_pkg::AXIS_W-1:0]            axis_r;
  logic [tfa_pkg::CAP_W-1:0]             cap_r;
  logic                                  half_r;

  logic [tfa_pkg::IDX_W-1:0]             in_idx;
  logic signed [tfa_pkg::VAL_W-1:0]      in_val;
  logic signed [tfa_pkg::VOLT_W-1:0]     cur_volt;
  logic signed [tfa_pkg::VAL_W-1:0]      cur_force;
  logic [tfa_pkg::VOLT_W:0]              volt_mag;
  logic                                  in_dz;
  logic                                  cur_set;
  logic [tfa_pkg::TERM_W-1:0]            term_issue;
  logic [tfa_pkg::COEF_IDX_W-1:0]        coef_idx;
  logic [tfa_pkg::MAT_IDX_W-1:0]         mat_idx;
  logic                                  thrust_xfer;

  tfa_pkg::mac_ctrl_t                    mac_ctrl;
  logic signed [tfa_pkg::MUL_A_W-1:0]    mac_a;
  logic signed [tfa_pkg::MUL_B_W-1:0]    mac_b;
  logic signed [tfa_pkg::VAL_W-1:0]      mac_addend;
  logic signed [tfa_pkg::ACC_W-1:0]      mac_acc;
  logic                                  mac_done;

  assign in_idx    = in_tdata[tfa_pkg::IDX_LSB +: tfa_pkg::IDX_W];
  assign in_val    = in_tdata[tfa_pkg::VAL_LSB +: tfa_pkg::VAL_W];
  assign in_tready = (state_r == S_IDLE);

  assign cur_volt  = volt_r[prop_r];
  assign cur_force = force_r[prop_r];
  assign volt_mag  = cur_volt[tfa_pkg::VOLT_W-1] ?
                     ((tfa_pkg::VOLT_W + 1)'(0) - {cur_volt[tfa_pkg::VOLT_W-1], cur_volt}) :
                     {1'b0, cur_volt};
  assign in_dz     = (volt_mag <= (tfa_pkg::VOLT_W + 1)'(dead_zone_r));
  assign cur_set   = (2 * int'(prop_r) >= tfa_pkg::NUM_PROP);
  assign coef_idx  = tfa_pkg::COEF_IDX_W'(tfa_pkg::POLY_TERMS * int'(cur_set) + int'(term_issue));
  assign mat_idx   = tfa_pkg::MAT_IDX_W'(tfa_pkg::NUM_PROP * int'(axis_r) + int'(prop_r));

  // Issue side of the shared unit
  always_comb begin
    mac_ctrl   = '0;
    mac_a      = '0;
    mac_b      = '0;
    mac_addend = '0;
    term_issue = '0;
    unique case (state_r)
      S_POLY, S_POLY_WAIT: begin
        term_issue = (state_r == S_POLY) ? '0 : term_r + 1'b1;
        if ((state_r == S_POLY && !in_dz) ||
            (state_r == S_POLY_WAIT && mac_done && term_r != TERM_LAST)) begin
          mac_ctrl.issue = 1'b1;
          mac_ctrl.mode  = tfa_pkg::MAC_HORNER;
          mac_ctrl.last  = 1'b1;
        end
        // first term: zero times v plus c0 loads the leading coefficient
        mac_a      = (state_r == S_POLY) ? '0 : $signed(mac_acc[tfa_pkg::HORNER_W-1:0]);
        mac_b      = tfa_pkg::MUL_B_W'(cur_volt);
        mac_addend = coef_r[coef_idx];
      end
      S_MAT: begin
        mac_ctrl.issue = 1'b1;
        mac_ctrl.mode  = half_r ? tfa_pkg::MAC_ADD_LO : tfa_pkg::MAC_ADD_HI;
        mac_ctrl.first = (prop_r == '0) && !half_r;
        mac_ctrl.last  = (prop_r == PROP_LAST) && half_r;
        mac_a          = tfa_pkg::MUL_A_W'(mat_r[mat_idx]);
        // thrust split into signed upper and unsigned lower 16-bit halves
        mac_b          = half_r ? {1'b0, cur_force[15:0]} :
                                  {cur_force[tfa_pkg::VAL_W-1], cur_force[tfa_pkg::VAL_W-1:16]};
      end
      default: ;
    endcase
  end

  tfa_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (mac_ctrl),
    .op_a   (mac_a),
    .op_b   (mac_b),
    .addend (mac_addend),
    .acc    (mac_acc),
    .done   (mac_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      dead_zone_r  <= tfa_pkg::DZ_RESET;
      out_tvalid_r <= 1'b0;
      prop_r       <= '0;
      term_r       <= '0;
      axis_r       <= '0;
      cap_r        <= '0;
      half_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        dead_zone_r <= cfg_wdata;
      end
      // completion reloads the output itself
      if (out_tvalid_r && out_tready && state_r != S_DONE) begin
        out_tvalid_r <= 1'b0;
      end
      if (mac_done && (state_r == S_MAT || state_r == S_MAT_WAIT)) begin
        axis_res_r[cap_r[tfa_pkg::AXIS_W-1:0]] <= sat32(mac_acc);
        cap_r <= cap_r + 1'b1;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            unique case (in_tuser)
              tfa_pkg::OP_COEF: begin
                if (int'(in_idx) < tfa_pkg::COEF_DEPTH) begin
                  coef_r[in_idx[tfa_pkg::COEF_IDX_W-1:0]] <= in_val;
                end
              end
              tfa_pkg::OP_MAT: begin
                if (int'(in_idx) < tfa_pkg::MAT_DEPTH) begin
                  mat_r[in_idx[tfa_pkg::MAT_IDX_W-1:0]] <= in_val;
                end
              end
              tfa_pkg::OP_THRUST: begin
                for (int p = 0; p < tfa_pkg::NUM_PROP; p++) begin
                  volt_r[p] <= in_tdata[tfa_pkg::VOLT_LSB + p * tfa_pkg::VOLT_W +: tfa_pkg::VOLT_W];
                end
                prop_r  <= '0;
                term_r  <= '0;
                state_r <= S_POLY;
              end
              default: ;
            endcase
          end
        end

        S_POLY: begin
          if (in_dz) begin
            force_r[prop_r] <= '0;
            if (prop_r == PROP_LAST) begin
              prop_r  <= '0;
              axis_r  <= '0;
              half_r  <= 1'b0;
              cap_r   <= '0;
              state_r <= S_MAT;
            end else begin
              prop_r <= prop_r + 1'b1;
            end
          end else begin
            term_r  <= '0;
            state_r <= S_POLY_WAIT;
          end
        end

        S_POLY_WAIT: begin
          if (mac_done) begin
            if (term_r == TERM_LAST) begin
              force_r[prop_r] <= sat32(mac_acc);
              term_r          <= '0;
              if (prop_r == PROP_LAST) begin
                prop_r  <= '0;
                axis_r  <= '0;
                half_r  <= 1'b0;
                cap_r   <= '0;
                state_r <= S_MAT;
              end else begin
                prop_r  <= prop_r + 1'b1;
                state_r <= S_POLY;
              end
            end else begin
              term_r <= term_r + 1'b1;
            end
          end
        end

        S_MAT: begin
          half_r <= ~half_r;
          if (half_r) begin
            if (prop_r == PROP_LAST) begin
              prop_r <= '0;
              if (axis_r == AXIS_LAST) begin
                state_r <= S_MAT_WAIT;
              end else begin
                axis_r <= axis_r + 1'b1;
              end
            end else begin
              prop_r <= prop_r + 1'b1;
            end
          end
        end

        S_MAT_WAIT: begin
          if (mac_done && cap_r == CAP_LAST) begin
            state_r <= S_DONE;
          end
        end

        S_DONE: begin
          // hold until the previous result has been transferred
          if (!out_tvalid_r || out_tready) begin
            for (int a = 0; a < tfa_pkg::NUM_AXES; a++) begin
              out_data_r[a * tfa_pkg::VAL_W +: tfa_pkg::VAL_W] <= axis_res_r[a];
            end
            out_tvalid_r <= 1'b1;
            state_r      <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  assign thrust_xfer = in_tvalid & in_tready & (in_tuser == tfa_pkg::OP_THRUST);

  `ASSERT_PROP(a_busy_after_thrust, thrust_xfer |=> !in_tready, "top: ready after thrust request")
  `ASSERT_NEVER(a_idle_no_done, state_r == S_IDLE && mac_done, "top: unit result while idle")
  `ASSERT_PROP(a_out_from_done, $rose(out_tvalid_r) |-> $past(state_r == S_DONE), "top: stray result")

endmodule

`default_nettype wire
